### hdl/ltpd_pkg.sv
package ltpd_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int KIND_W   = 2;
    localparam int OUT_W    = 104;
    localparam int CFG_IDX_W = 2;

    // queue depth between decode and execute
    localparam int QUEUE_DEPTH_DEF = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_RANGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDR    = 2'd3;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_LINE_BASE   = 8'hFF;
    localparam logic [BYTE_W-1:0] RST_LINE_RANGE  = 8'd8;
    localparam logic [BYTE_W-1:0] RST_OPCODE_BASE = 8'd9;
    localparam logic [BYTE_W-1:0] RST_MAX_ADDR    = 8'd30;

    // standard opcodes
    localparam logic [BYTE_W-1:0] OPC_EXTENDED  = 8'h00;
    localparam logic [BYTE_W-1:0] OPC_COPY      = 8'h01;
    localparam logic [BYTE_W-1:0] OPC_ADV_PC    = 8'h02;
    localparam logic [BYTE_W-1:0] OPC_ADV_LINE  = 8'h03;
    localparam logic [BYTE_W-1:0] OPC_SET_FILE  = 8'h04;
    localparam logic [BYTE_W-1:0] OPC_CONST_ADD = 8'h08;

    // extended opcodes
    localparam logic [BYTE_W-1:0] EXT_END_SEQ   = 8'h01;
    localparam logic [BYTE_W-1:0] EXT_NEG_HIDE  = 8'h40;
    localparam logic [BYTE_W-1:0] EXT_RSV_LAST  = 8'h7F;

    // number of operand bytes that still contribute bits
    localparam logic [2:0] LEB_MAX_SHIFT = 3'd5;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ROW   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_LEB,
        PH_EXT_SIZE,
        PH_EXT_OP,
        PH_SKIP
    } t_phase;

    typedef enum logic [3:0] {
        CMD_ADV_PC,
        CMD_ADV_LINE,
        CMD_SET_FILE,
        CMD_COPY,
        CMD_CONST_ADD,
        CMD_SPECIAL,
        CMD_NEG_HIDDEN,
        CMD_END,
        CMD_ERROR
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op             op;
        logic [WORD_W-1:0]   value;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] line_base;
        logic [BYTE_W-1:0] line_range;
        logic [BYTE_W-1:0] opcode_base;
        logic [BYTE_W-1:0] max_addr_step;
    } t_cfg;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FIN
    } t_back_state;

endpackage

### hdl/ltpd_front.sv
module ltpd_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ltpd_pkg::t_cfg             i_cfg,
    input  logic                       i_accept,
    input  logic [ltpd_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_push,
    output ltpd_pkg::t_cmd             o_cmd
);
    import ltpd_pkg::*;

    t_phase              r_phase, n_phase;
    t_cmd_op             r_pending, n_pending;
    logic [WORD_W-1:0]   r_accum, n_accum;
    logic [2:0]          r_shift, n_shift;
    logic [BYTE_W-1:0]   r_skip, n_skip;
    logic [WORD_W-1:0]   leb_bits;
    logic [WORD_W-1:0]   accum_new;

    // operand bits placed at the current group position
    always_comb begin
        case (r_shift)
            3'd0:    leb_bits = {25'd0, i_byte[6:0]};
            3'd1:    leb_bits = {18'd0, i_byte[6:0], 7'd0};
            3'd2:    leb_bits = {11'd0, i_byte[6:0], 14'd0};
            3'd3:    leb_bits = {4'd0, i_byte[6:0], 21'd0};
            3'd4:    leb_bits = {i_byte[3:0], 28'd0};
            default: leb_bits = '0;
        endcase
    end

    assign accum_new = r_accum | leb_bits;

    // decode phase and command generation
    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_accum   = r_accum;
        n_shift   = r_shift;
        n_skip    = r_skip;
        o_push    = 1'b0;
        o_cmd     = '{op: CMD_ERROR, value: '0};
        if (i_accept) begin
            case (r_phase)
                PH_OPCODE: begin
                    if (i_byte == OPC_EXTENDED) begin
                        n_phase = PH_EXT_SIZE;
                    end else if (i_byte < i_cfg.opcode_base) begin
                        case (i_byte)
                            OPC_COPY: begin
                                o_push = 1'b1;
                                o_cmd.op = CMD_COPY;
                            end
                            OPC_ADV_PC: begin
                                n_pending = CMD_ADV_PC;
                                n_accum   = '0;
                                n_shift   = '0;
                                n_phase   = PH_LEB;
                            end
                            OPC_ADV_LINE: begin
                                n_pending = CMD_ADV_LINE;
                                n_accum   = '0;
                                n_shift   = '0;
                                n_phase   = PH_LEB;
                            end
                            OPC_SET_FILE: begin
                                n_pending = CMD_SET_FILE;
                                n_accum   = '0;
                                n_shift   = '0;
                                n_phase   = PH_LEB;
                            end
                            OPC_CONST_ADD: begin
                                o_push = 1'b1;
                                o_cmd.op = CMD_CONST_ADD;
                            end
                            default: begin
                                o_push    = 1'b1;
                                o_cmd.op  = CMD_ERROR;
                                n_pending = CMD_ADV_PC;
                                n_accum   = '0;
                                n_shift   = '0;
                                n_skip    = '0;
                            end
                        endcase
                    end else begin
                        o_push    = 1'b1;
                        o_cmd.op  = CMD_SPECIAL;
                        o_cmd.value = {{(WORD_W-BYTE_W){1'b0}}, i_byte - i_cfg.opcode_base};
                    end
                end
                PH_LEB: begin
                    if (r_shift < LEB_MAX_SHIFT) begin
                        n_shift = r_shift + 3'd1;
                    end
                    if (i_byte[7]) begin
                        n_accum = accum_new;
                    end else begin
                        o_push      = 1'b1;
                        o_cmd.op    = r_pending;
                        o_cmd.value = accum_new;
                        n_accum     = '0;
                        n_shift     = '0;
                        n_pending   = CMD_ADV_PC;
                        n_phase     = PH_OPCODE;
                    end
                end
                PH_EXT_SIZE: begin
                    n_skip  = (i_byte == '0) ? '0 : i_byte - 8'd1;
                    n_phase = PH_EXT_OP;
                end
                PH_EXT_OP: begin
                    if (i_byte == EXT_END_SEQ) begin
                        o_push    = 1'b1;
                        o_cmd.op  = CMD_END;
                        n_phase   = PH_OPCODE;
                        n_pending = CMD_ADV_PC;
                        n_accum   = '0;
                        n_shift   = '0;
                        n_skip    = '0;
                    end else if (i_byte >= EXT_NEG_HIDE && i_byte <= EXT_RSV_LAST) begin
                        if (i_byte == EXT_NEG_HIDE) begin
                            o_push   = 1'b1;
                            o_cmd.op = CMD_NEG_HIDDEN;
                        end
                        n_phase = (r_skip == '0) ? PH_OPCODE : PH_SKIP;
                    end else begin
                        o_push    = 1'b1;
                        o_cmd.op  = CMD_ERROR;
                        n_phase   = PH_OPCODE;
                        n_pending = CMD_ADV_PC;
                        n_accum   = '0;
                        n_shift   = '0;
                        n_skip    = '0;
                    end
                end
                PH_SKIP: begin
                    n_skip = (r_skip != '0) ? r_skip - 8'd1 : '0;
                    if (n_skip == '0) begin
                        n_phase = PH_OPCODE;
                    end
                end
                default: begin
                    n_phase = PH_OPCODE;
                end
            endcase
        end
    end

    // decode state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OPCODE;
            r_pending <= CMD_ADV_PC;
            r_accum   <= '0;
            r_shift   <= '0;
            r_skip    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_accum   <= n_accum;
            r_shift   <= n_shift;
            r_skip    <= n_skip;
        end
    end

endmodule

### hdl/ltpd_queue.sv
module ltpd_queue #(
    parameter int DEPTH = ltpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ltpd_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output ltpd_pkg::t_cmd o_head
);
    import ltpd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_entry[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### hdl/ltpd_back.sv
module ltpd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ltpd_pkg::t_cfg              i_cfg,
    input  logic                        i_cmd_valid,
    input  ltpd_pkg::t_cmd              i_cmd,
    output logic                        o_pop,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [ltpd_pkg::KIND_W-1:0] o_kind,
    output logic                        o_row_valid,
    output logic [ltpd_pkg::WORD_W-1:0] o_file_index,
    output logic signed [ltpd_pkg::WORD_W-1:0] o_line,
    output logic [ltpd_pkg::WORD_W-1:0] o_code_offset,
    output logic                        o_hidden
);
    import ltpd_pkg::*;

    t_back_state        r_state, n_state;
    logic [WORD_W-1:0]  r_file, n_file;
    logic [WORD_W-1:0]  r_line, n_line;
    logic [WORD_W-1:0]  r_offset, n_offset;
    logic               r_hidden, n_hidden;
    logic               r_mod, n_mod;
    logic [BYTE_W:0]    r_rem, n_rem;
    logic [BYTE_W-1:0]  r_quo, n_quo;
    logic               r_step, n_step;

    logic               r_out_valid, n_out_valid;
    logic [KIND_W-1:0]  r_out_kind, n_out_kind;
    logic               r_out_row, n_out_row;
    logic [WORD_W-1:0]  r_out_file, n_out_file;
    logic [WORD_W-1:0]  r_out_line, n_out_line;
    logic [WORD_W-1:0]  r_out_offset, n_out_offset;
    logic               r_out_hidden, n_out_hidden;

    logic               can_emit;
    logic [BYTE_W:0]    divisor;
    logic [WORD_W-1:0]  base_ext;

    assign can_emit = !r_out_valid || i_out_ready;
    assign divisor  = (i_cfg.line_range == '0) ? 9'd1 : {1'b0, i_cfg.line_range};
    assign base_ext = {{(WORD_W-BYTE_W){i_cfg.line_base[BYTE_W-1]}}, i_cfg.line_base};

    // command execution, divide steps and result register
    always_comb begin
        logic [BYTE_W:0]   rem_v;
        logic [BYTE_W-1:0] quo_v;
        rem_v        = r_rem;
        quo_v        = r_quo;
        n_state      = r_state;
        n_file       = r_file;
        n_line       = r_line;
        n_offset     = r_offset;
        n_hidden     = r_hidden;
        n_mod        = r_mod;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_step       = r_step;
        o_pop        = 1'b0;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_kind   = r_out_kind;
        n_out_row    = r_out_row;
        n_out_file   = r_out_file;
        n_out_line   = r_out_line;
        n_out_offset = r_out_offset;
        n_out_hidden = r_out_hidden;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        CMD_COPY: begin
                            if (can_emit) begin
                                o_pop        = 1'b1;
                                n_out_valid  = 1'b1;
                                n_out_kind   = KIND_ROW;
                                n_out_row    = 1'b1;
                                n_out_file   = r_file;
                                n_out_line   = r_line;
                                n_out_offset = r_offset;
                                n_out_hidden = r_hidden;
                                n_mod        = 1'b0;
                            end
                        end
                        CMD_ADV_PC: begin
                            o_pop    = 1'b1;
                            n_offset = r_offset + i_cmd.value;
                            n_mod    = 1'b1;
                        end
                        CMD_ADV_LINE: begin
                            o_pop  = 1'b1;
                            n_line = r_line + i_cmd.value;
                            n_mod  = 1'b1;
                        end
                        CMD_SET_FILE: begin
                            o_pop  = 1'b1;
                            n_file = i_cmd.value;
                            n_mod  = 1'b1;
                        end
                        CMD_CONST_ADD: begin
                            o_pop    = 1'b1;
                            n_offset = r_offset
                                + {{(WORD_W-BYTE_W){1'b0}}, i_cfg.max_addr_step};
                            n_mod    = 1'b1;
                        end
                        CMD_NEG_HIDDEN: begin
                            o_pop    = 1'b1;
                            n_hidden = !r_hidden;
                            n_mod    = 1'b1;
                        end
                        CMD_SPECIAL: begin
                            o_pop   = 1'b1;
                            n_rem   = '0;
                            n_quo   = i_cmd.value[BYTE_W-1:0];
                            n_step  = 1'b0;
                            n_state = BK_DIV;
                        end
                        CMD_END: begin
                            if (can_emit) begin
                                o_pop        = 1'b1;
                                n_out_valid  = 1'b1;
                                n_out_kind   = KIND_END;
                                n_out_row    = r_mod;
                                n_out_file   = r_mod ? r_file : '0;
                                n_out_line   = r_mod ? r_line : '0;
                                n_out_offset = r_mod ? r_offset : '0;
                                n_out_hidden = r_mod && r_hidden;
                                n_file       = 32'd1;
                                n_line       = 32'd1;
                                n_offset     = '0;
                                n_hidden     = 1'b0;
                                n_mod        = 1'b0;
                            end
                        end
                        default: begin
                            // error: result carries no row
                            if (can_emit) begin
                                o_pop        = 1'b1;
                                n_out_valid  = 1'b1;
                                n_out_kind   = KIND_ERROR;
                                n_out_row    = 1'b0;
                                n_out_file   = '0;
                                n_out_line   = '0;
                                n_out_offset = '0;
                                n_out_hidden = 1'b0;
                                n_file       = 32'd1;
                                n_line       = 32'd1;
                                n_offset     = '0;
                                n_hidden     = 1'b0;
                                n_mod        = 1'b0;
                            end
                        end
                    endcase
                end
            end
            BK_DIV: begin
                // four restoring divide steps per cycle
                for (int k = 0; k < 4; k++) begin
                    rem_v = {rem_v[BYTE_W-1:0], quo_v[BYTE_W-1]};
                    quo_v = {quo_v[BYTE_W-2:0], 1'b0};
                    if (rem_v >= divisor) begin
                        rem_v    = rem_v - divisor;
                        quo_v[0] = 1'b1;
                    end
                end
                n_rem  = rem_v;
                n_quo  = quo_v;
                n_step = 1'b1;
                if (r_step) begin
                    n_state = BK_FIN;
                end
            end
            BK_FIN: begin
                if (can_emit) begin
                    n_offset     = r_offset + {{(WORD_W-BYTE_W){1'b0}}, r_quo};
                    n_line       = r_line + base_ext
                        + {{(WORD_W-BYTE_W-1){1'b0}}, r_rem};
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_ROW;
                    n_out_row    = 1'b1;
                    n_out_file   = r_file;
                    n_out_line   = n_line;
                    n_out_offset = n_offset;
                    n_out_hidden = r_hidden;
                    n_mod        = 1'b0;
                    n_state      = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // control and row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_file      <= 32'd1;
            r_line      <= 32'd1;
            r_offset    <= '0;
            r_hidden    <= 1'b0;
            r_mod       <= 1'b0;
            r_step      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_file      <= n_file;
            r_line      <= n_line;
            r_offset    <= n_offset;
            r_hidden    <= n_hidden;
            r_mod       <= n_mod;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // divider and result payload
    always_ff @(posedge i_clk) begin
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_out_kind   <= n_out_kind;
        r_out_row    <= n_out_row;
        r_out_file   <= n_out_file;
        r_out_line   <= n_out_line;
        r_out_offset <= n_out_offset;
        r_out_hidden <= n_out_hidden;
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_row_valid   = r_out_row;
    assign o_file_index  = r_out_file;
    assign o_line        = r_out_line;
    assign o_code_offset = r_out_offset;
    assign o_hidden      = r_out_hidden;

endmodule

### hdl/line_table_program_decoder.sv
// Line-number program decoder. Program bytes enter on the slave stream, one
// per transaction; the decode front takes a byte in every cycle while its
// command queue (QUEUE_DEPTH entries) has room, so operand, extended-size and
// skipped bytes each pass through the front at that rate. Each decoded
// command (copy, advance, set-file, const-add-pc, negate-hidden, end, error
// or special) then runs in the execute stage; a special opcode first runs a
// radix-16 restoring divider by line_range in BK_DIV. Rows, end marks and
// errors leave through a result register on the master stream, which the
// execute stage refills as soon as the held result is taken. Registers are
// written through the plain write port and should change only while idle.
module line_table_program_decoder #(
    parameter int QUEUE_DEPTH = ltpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream, tdata: data_byte
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ltpd_pkg::BYTE_W-1:0]    i_s_tdata,
    // master stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: row_valid, file_index, line, code_offset, hidden, zero pad
    output logic [ltpd_pkg::OUT_W-1:0]     o_m_tdata,
    // tuser: kind
    output logic [ltpd_pkg::KIND_W-1:0]    o_m_tuser,
    // register write port
    input  logic                           i_cfg_we,
    input  logic [ltpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ltpd_pkg::BYTE_W-1:0]    i_cfg_wdata
);
    import ltpd_pkg::*;

    t_cfg               r_cfg;
    logic               s_accept;
    logic               push;
    t_cmd               push_cmd;
    logic               q_full;
    logic               q_empty;
    t_cmd               q_head;
    logic               pop;
    logic               row_valid;
    logic [WORD_W-1:0]  file_index;
    logic signed [WORD_W-1:0] line;
    logic [WORD_W-1:0]  code_offset;
    logic               hidden;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_base     <= RST_LINE_BASE;
            r_cfg.line_range    <= RST_LINE_RANGE;
            r_cfg.opcode_base   <= RST_OPCODE_BASE;
            r_cfg.max_addr_step <= RST_MAX_ADDR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINE_BASE:   r_cfg.line_base     <= i_cfg_wdata;
                CFG_LINE_RANGE:  r_cfg.line_range    <= i_cfg_wdata;
                CFG_OPCODE_BASE: r_cfg.opcode_base   <= i_cfg_wdata;
                CFG_MAX_ADDR:    r_cfg.max_addr_step <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input transaction
    assign o_s_tready = !q_full;
    assign s_accept   = i_s_tvalid && !q_full;

    ltpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (s_accept),
        .i_byte   (i_s_tdata),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    ltpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    ltpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (!q_empty),
        .i_cmd         (q_head),
        .o_pop         (pop),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_kind        (o_m_tuser),
        .o_row_valid   (row_valid),
        .o_file_index  (file_index),
        .o_line        (line),
        .o_code_offset (code_offset),
        .o_hidden      (hidden)
    );

    // result packing, lowest field first
    assign o_m_tdata = {6'd0, hidden, code_offset, line, file_index, row_valid};

endmodule
